FILE: rtl/fbpa_pkg.sv
// shared types, codes and constants of the fixed block pool allocator
package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;

  localparam int BASE_W   = 32;
  localparam int ALIGN_W  = 8;
  localparam int SIZE_W   = 16;
  localparam int POOL_W   = 24;
  localparam int IDX_W    = 10;
  localparam int LIVE_W   = 11;
  localparam int USAGE_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [BASE_W-1:0]  BASE_RST  = '0;
  localparam logic [ALIGN_W-1:0] ALIGN_RST = 8'd8;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd64;
  localparam logic [POOL_W-1:0]  POOL_RST  = 24'd65536;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } rsp_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_ALIGN = 2'd1,
    CFG_SIZE  = 2'd2,
    CFG_POOL  = 2'd3
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // request transfer, latch and launch link access
    logic exec;        // apply alloc/free and load the response
    logic div_start;   // start block count division
    logic sweep;       // write one link entry of the rebuild
    logic clear_done;  // respond at the end of the rebuild
  } fbpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sweep_last;
    logic rsp_free;
  } fbpa_flags_t;

endpackage

FILE: rtl/fbpa_ifs.sv
// request and response channel interfaces
interface fbpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [fbpa_pkg::IDX_W-1:0]    block_index;
  logic [fbpa_pkg::SIZE_W-1:0]   req_size;

  modport source (output valid, req_type, block_index, req_size, input ready);
  modport sink   (input valid, req_type, block_index, req_size, output ready);
endinterface

interface fbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [fbpa_pkg::IDX_W-1:0]    granted_index;
  logic [fbpa_pkg::BASE_W-1:0]   block_address;
  logic [fbpa_pkg::LIVE_W-1:0]   live_count;
  logic [fbpa_pkg::USAGE_W-1:0]  usage_bytes;

  modport source (output valid, status, granted_index, block_address, live_count,
                  usage_bytes, input ready);
  modport sink   (input valid, status, granted_index, block_address, live_count,
                  usage_bytes, output ready);
endinterface

FILE: rtl/fbpa_div.sv
// restoring divider, one quotient bit per cycle, for the block count
module fbpa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fbpa_pkg::POOL_W-1:0]   dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [fbpa_pkg::POOL_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(fbpa_pkg::POOL_W + 1);

  logic [CNT_W-1:0]               cnt;
  logic [fbpa_pkg::SIZE_W-1:0]    rem;
  logic [fbpa_pkg::POOL_W-1:0]    quo;
  logic [fbpa_pkg::SIZE_W:0]      trial;
  logic                           fits;

  assign trial    = {rem, quo[fbpa_pkg::POOL_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(fbpa_pkg::POOL_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? fbpa_pkg::SIZE_W'(trial - {1'b0, divisor})
                  : trial[fbpa_pkg::SIZE_W-1:0];
      quo <= {quo[fbpa_pkg::POOL_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/fbpa_ctrl.sv
// sequencing state machine of the allocator
module fbpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_type,
  output logic                  req_ready,
  input  fbpa_pkg::fbpa_flags_t flags,
  output fbpa_pkg::fbpa_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_START = 5'b00001,
    S_DIV   = 5'b00010,
    S_SWEEP = 5'b00100,
    S_IDLE  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   clear_pend, clear_pend_next;
  logic   xfer;

  assign req_ready = (state == S_IDLE) && flags.rsp_free;
  assign xfer      = req_valid && req_ready;

  always_comb begin
    state_next      = state;
    clear_pend_next = clear_pend;
    cmd             = '0;
    unique case (state)
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (flags.div_done) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (flags.sweep_last) begin
          cmd.clear_done  = clear_pend;
          clear_pend_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (xfer) begin
          cmd.take = 1'b1;
          if (fbpa_pkg::req_type_t'(req_type) == fbpa_pkg::REQ_CLEAR) begin
            clear_pend_next = 1'b1;
            state_next      = S_START;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_START;
      clear_pend <= 1'b0;
    end else begin
      state      <= state_next;
      clear_pend <= clear_pend_next;
    end
  end

endmodule

FILE: rtl/fbpa_dp.sv
// datapath: config registers, link memory, list head, counters, response register
module fbpa_dp #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                        req_type,
  input  logic [fbpa_pkg::IDX_W-1:0]        block_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]       req_size,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic [1:0]                        rsp_status,
  output logic [fbpa_pkg::IDX_W-1:0]        rsp_index,
  output logic [fbpa_pkg::BASE_W-1:0]       rsp_address,
  output logic [fbpa_pkg::LIVE_W-1:0]       rsp_live,
  output logic [fbpa_pkg::USAGE_W-1:0]      rsp_usage,
  input  fbpa_pkg::fbpa_cmd_t               cmd,
  output fbpa_pkg::fbpa_flags_t             flags
);

  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int AW   = $clog2(MAX_BLOCKS);
  localparam int CMPW = (CW > fbpa_pkg::IDX_W) ? CW : fbpa_pkg::IDX_W;
  localparam int PW   = CW + fbpa_pkg::SIZE_W;
  localparam logic [CW-1:0] NULL_LINK = CW'(MAX_BLOCKS);

  // configuration
  logic [fbpa_pkg::BASE_W-1:0]  base_address;
  logic [fbpa_pkg::ALIGN_W-1:0] object_alignment;
  logic [fbpa_pkg::SIZE_W-1:0]  object_size;
  logic [fbpa_pkg::POOL_W-1:0]  pool_bytes;

  // list state
  logic [CW-1:0]                list_head;
  logic [CW-1:0]                block_total;
  logic [CW-1:0]                live_blocks;
  logic [fbpa_pkg::USAGE_W-1:0] usage_total;

  // link memory
  logic [CW-1:0] next_link [MAX_BLOCKS];
  logic [CW-1:0] link_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_re;

  // rebuild
  logic [AW-1:0]                sweep_i;
  logic [CW-1:0]                sweep_link;
  logic                         sweep_last;
  logic [fbpa_pkg::ALIGN_W-1:0] align_mask;
  logic [fbpa_pkg::ALIGN_W-1:0] adj;
  logic [fbpa_pkg::POOL_W-1:0]  dividend;
  logic                         div_done;
  logic [fbpa_pkg::POOL_W-1:0]  quotient;
  logic [CW-1:0]                count_capped;

  // request handling
  fbpa_pkg::req_type_t          in_type;
  fbpa_pkg::rsp_status_t        in_status;
  logic [CMPW-1:0]              idx_w;
  logic                         alloc_ok;
  logic                         idx_bad;
  logic [CW-1:0]                mul_a;
  logic [PW-1:0]                prod_full;

  fbpa_pkg::req_type_t          op_q;
  fbpa_pkg::rsp_status_t        stat_q;
  logic [CW-1:0]                gidx_q;
  logic [CW-1:0]                fidx_q;
  logic [fbpa_pkg::SIZE_W-1:0]  size_q;
  logic [fbpa_pkg::BASE_W-1:0]  prod_q;

  logic                         alloc_go;
  logic                         free_go;
  logic [CW-1:0]                live_next;
  logic [fbpa_pkg::USAGE_W-1:0] usage_next;
  logic [fbpa_pkg::IDX_W-1:0]   index_next;
  logic [fbpa_pkg::BASE_W-1:0]  addr_next;
  logic [fbpa_pkg::BASE_W-1:0]  block_addr;
  logic                         clear_rsp;

  // alignment adjustment: (-base) & (alignment - 1), zero alignment acts as one
  assign align_mask = (object_alignment == '0) ? '0 : object_alignment - 1'b1;
  assign adj        = (~base_address[fbpa_pkg::ALIGN_W-1:0] + 1'b1) & align_mask;
  assign dividend   = (pool_bytes >= fbpa_pkg::POOL_W'(adj))
                      ? pool_bytes - fbpa_pkg::POOL_W'(adj) : '0;
  assign count_capped = (object_size == '0) ? '0
                      : (quotient > fbpa_pkg::POOL_W'(MAX_BLOCKS)) ? NULL_LINK
                      : CW'(quotient);

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (object_size),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sweep_last = sweep_i == AW'(MAX_BLOCKS - 1);
  assign sweep_link = ((CW'(sweep_i) + 1'b1) < block_total) ? CW'(sweep_i) + 1'b1 : NULL_LINK;

  // take decode
  assign in_type  = fbpa_pkg::req_type_t'(req_type);
  assign idx_w    = CMPW'(block_index);
  assign alloc_ok = list_head < block_total;
  assign idx_bad  = idx_w >= CMPW'(block_total);

  always_comb begin
    unique case (in_type)
      fbpa_pkg::REQ_ALLOC: in_status = alloc_ok ? fbpa_pkg::STAT_OK : fbpa_pkg::STAT_EMPTY;
      fbpa_pkg::REQ_FREE:  in_status = idx_bad ? fbpa_pkg::STAT_RANGE : fbpa_pkg::STAT_OK;
      fbpa_pkg::REQ_CLEAR: in_status = fbpa_pkg::STAT_OK;
      fbpa_pkg::REQ_NOP:   in_status = fbpa_pkg::STAT_OK;
      default:             in_status = fbpa_pkg::STAT_OK;
    endcase
  end

  assign mul_a     = (in_type == fbpa_pkg::REQ_FREE) ? idx_w[CW-1:0] : list_head;
  assign prod_full = PW'(mul_a) * PW'(object_size);

  // link memory ports: rebuild sweep or free push write, alloc pop read
  assign mem_re    = cmd.take && (in_type == fbpa_pkg::REQ_ALLOC) && alloc_ok;
  assign mem_we    = cmd.sweep || (cmd.take && (in_type == fbpa_pkg::REQ_FREE) && !idx_bad);
  assign mem_waddr = cmd.sweep ? sweep_i : idx_w[AW-1:0];
  assign mem_wdata = cmd.sweep ? sweep_link : list_head;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rdata <= next_link[list_head[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sweep_i <= '0;
    end else if (cmd.sweep && !sweep_last) begin
      sweep_i <= sweep_i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q   <= in_type;
      stat_q <= in_status;
      gidx_q <= list_head;
      fidx_q <= idx_w[CW-1:0];
      size_q <= req_size;
      prod_q <= fbpa_pkg::BASE_W'(prod_full);
    end
  end

  // execute step
  assign alloc_go   = (op_q == fbpa_pkg::REQ_ALLOC) && (stat_q == fbpa_pkg::STAT_OK);
  assign free_go    = (op_q == fbpa_pkg::REQ_FREE) && (stat_q == fbpa_pkg::STAT_OK);
  assign block_addr = base_address + fbpa_pkg::BASE_W'(adj) + prod_q;

  always_comb begin
    live_next  = live_blocks;
    usage_next = usage_total;
    index_next = '0;
    addr_next  = '0;
    if (alloc_go) begin
      if (live_blocks < NULL_LINK) begin
        live_next = live_blocks + 1'b1;
      end
      usage_next = usage_total + fbpa_pkg::USAGE_W'(size_q);
      index_next = fbpa_pkg::IDX_W'(gidx_q);
      addr_next  = block_addr;
    end else if (free_go) begin
      if (live_blocks != '0) begin
        live_next = live_blocks - 1'b1;
      end
      usage_next = usage_total - fbpa_pkg::USAGE_W'(object_size);
      addr_next  = block_addr;
    end
  end

  assign clear_rsp = cmd.sweep && sweep_last && cmd.clear_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address     <= fbpa_pkg::BASE_RST;
      object_alignment <= fbpa_pkg::ALIGN_RST;
      object_size      <= fbpa_pkg::SIZE_RST;
      pool_bytes       <= fbpa_pkg::POOL_RST;
      list_head        <= NULL_LINK;
      block_total      <= '0;
      live_blocks      <= '0;
      usage_total      <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (fbpa_pkg::cfg_reg_t'(cfg_index))
          fbpa_pkg::CFG_BASE:  base_address     <= cfg_data;
          fbpa_pkg::CFG_ALIGN: object_alignment <= cfg_data[fbpa_pkg::ALIGN_W-1:0];
          fbpa_pkg::CFG_SIZE:  object_size      <= cfg_data[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::CFG_POOL:  pool_bytes       <= cfg_data[fbpa_pkg::POOL_W-1:0];
          default: ;
        endcase
      end
      if (div_done) begin
        block_total <= count_capped;
      end
      if (cmd.sweep && sweep_last) begin
        list_head   <= (block_total != '0) ? '0 : NULL_LINK;
        live_blocks <= '0;
      end
      if (cmd.exec) begin
        live_blocks <= live_next;
        usage_total <= usage_next;
        if (alloc_go) begin
          list_head <= link_rdata;
        end else if (free_go) begin
          list_head <= fidx_q;
        end
      end
      if (cmd.exec || clear_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_status  <= stat_q;
      rsp_index   <= index_next;
      rsp_address <= addr_next;
      rsp_live    <= fbpa_pkg::LIVE_W'(live_next);
      rsp_usage   <= usage_next;
    end else if (clear_rsp) begin
      rsp_status  <= fbpa_pkg::STAT_OK;
      rsp_index   <= '0;
      rsp_address <= '0;
      rsp_live    <= '0;
      rsp_usage   <= usage_total;
    end
  end

  assign flags.div_done   = div_done;
  assign flags.sweep_last = sweep_last;
  assign flags.rsp_free   = !rsp_valid || rsp_ready;

endmodule

FILE: rtl/fixed_block_pool_allocator_top.sv
// top level of the fixed block pool allocator
// allocate, free and no-op: result registered in the execute state that follows the request transfer;
// no request taken meanwhile (the link memory read is registered) nor while the response is stalled
// clear: result after the 24-step block count divider and then the rebuild of the link memory,
// one entry rebuilt per cycle
// reset: synchronous; restores register defaults, zeroes usage and live count, then
// rebuilds the chain the same way, no request taken until the rebuild ends
module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  fbpa_req_if.sink                         req,
  fbpa_rsp_if.source                       rsp
);

  fbpa_pkg::fbpa_cmd_t   cmd;
  fbpa_pkg::fbpa_flags_t flags;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req.req_type),
    .block_index (req.block_index),
    .req_size    (req.req_size),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_status  (rsp.status),
    .rsp_index   (rsp.granted_index),
    .rsp_address (rsp.block_address),
    .rsp_live    (rsp.live_count),
    .rsp_usage   (rsp.usage_bytes),
    .cmd         (cmd),
    .flags       (flags)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the fixed block pool allocator: directed table, then random phases
module testbench;
  import fbpa_pkg::*;

  localparam int NBLK      = MAX_BLOCKS_DEF;
  localparam int LINK_NULL = NBLK;

  typedef struct packed {
    rsp_status_t        status;
    logic [IDX_W-1:0]   gidx;
    logic [BASE_W-1:0]  addr;
    logic [LIVE_W-1:0]  live;
    logic [USAGE_W-1:0] usage;
  } pool_rsp_t;

  typedef struct {
    bit               is_cfg;
    cfg_reg_t         reg_sel;
    logic [31:0]      reg_val;
    req_type_t        kind;
    logic [IDX_W-1:0] idx;
    logic [15:0]      size;
    bit               typed;
    pool_rsp_t        want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // allocator mirror
  logic [BASE_W-1:0]  cfg_base;
  logic [ALIGN_W-1:0] cfg_align;
  logic [SIZE_W-1:0]  cfg_osize;
  logic [POOL_W-1:0]  cfg_pool;
  logic [LIVE_W-1:0]  link_mem [NBLK];
  logic [LIVE_W-1:0]  free_head;
  logic [LIVE_W-1:0]  block_cnt;
  logic [LIVE_W-1:0]  live_cnt;
  logic [USAGE_W-1:0] usage_cnt;

  pool_rsp_t due_rsp_q[$];
  int        fail_cnt = 0;
  int        burst_left = 0;
  int        rx_mode = 0;
  int        rx_left = 0;

  function automatic logic [31:0] align_off(logic [31:0] base, logic [7:0] align);
    logic [31:0] a;
    a = (align == 8'd0) ? 32'd1 : {24'd0, align};
    return (32'd0 - base) & (a - 32'd1);
  endfunction

  function automatic logic [31:0] block_addr(logic [IDX_W-1:0] idx);
    return cfg_base + align_off(cfg_base, cfg_align) + {22'd0, idx} * {16'd0, cfg_osize};
  endfunction

  function automatic void pool_rebuild();
    logic [31:0] adj;
    logic [31:0] n;
    adj = align_off(cfg_base, cfg_align);
    n = 32'd0;
    if (cfg_osize != 16'd0 && {8'd0, cfg_pool} >= adj) begin
      n = ({8'd0, cfg_pool} - adj) / {16'd0, cfg_osize};
    end
    if (n > NBLK) begin
      n = NBLK;
    end
    block_cnt = n[LIVE_W-1:0];
    for (int i = 0; i < NBLK; i++) begin
      link_mem[i] = (i + 1 < n) ? LIVE_W'(i + 1) : LIVE_W'(LINK_NULL);
    end
    free_head = (n != 0) ? '0 : LIVE_W'(LINK_NULL);
    live_cnt = '0;
  endfunction

  function automatic void pool_config(cfg_reg_t sel, logic [31:0] val);
    case (sel)
      CFG_BASE:  cfg_base  = val;
      CFG_ALIGN: cfg_align = val[ALIGN_W-1:0];
      CFG_SIZE:  cfg_osize = val[SIZE_W-1:0];
      CFG_POOL:  cfg_pool  = val[POOL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic pool_rsp_t pool_step(req_type_t kind, logic [IDX_W-1:0] idx,
                                          logic [15:0] size);
    pool_rsp_t r;
    r = '0;
    r.status = STAT_OK;
    case (kind)
      REQ_ALLOC: begin
        if (free_head >= block_cnt) begin
          r.status = STAT_EMPTY;
        end else begin
          r.gidx = free_head[IDX_W-1:0];
          r.addr = block_addr(r.gidx);
          free_head = link_mem[r.gidx];
          usage_cnt = usage_cnt + size;
          if (live_cnt < NBLK) live_cnt = live_cnt + 1'b1;
        end
      end
      REQ_FREE: begin
        if ({1'b0, idx} >= block_cnt) begin
          r.status = STAT_RANGE;
        end else begin
          link_mem[idx] = free_head;
          free_head = {1'b0, idx};
          r.addr = block_addr(idx);
          usage_cnt = usage_cnt - cfg_osize;
          if (live_cnt > 0) live_cnt = live_cnt - 1'b1;
        end
      end
      REQ_CLEAR: pool_rebuild();
      default: ;
    endcase
    r.live  = live_cnt;
    r.usage = usage_cnt;
    return r;
  endfunction

  function automatic dir_row_t row_req(req_type_t kind, logic [IDX_W-1:0] idx,
                                       logic [15:0] size);
    dir_row_t row;
    row = '{reg_sel: CFG_BASE, kind: REQ_NOP, default: '0};
    row.kind = kind;
    row.idx  = idx;
    row.size = size;
    return row;
  endfunction

  function automatic dir_row_t row_chk(req_type_t kind, logic [IDX_W-1:0] idx,
                                       logic [15:0] size, rsp_status_t status,
                                       logic [IDX_W-1:0] gidx, logic [31:0] addr,
                                       logic [LIVE_W-1:0] live, logic [31:0] usage);
    dir_row_t row;
    row = row_req(kind, idx, size);
    row.typed = 1'b1;
    row.want.status = status;
    row.want.gidx   = gidx;
    row.want.addr   = addr;
    row.want.live   = live;
    row.want.usage  = usage;
    return row;
  endfunction

  function automatic dir_row_t row_cfg(cfg_reg_t sel, logic [31:0] val);
    dir_row_t row;
    row = '{reg_sel: CFG_BASE, kind: REQ_NOP, default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  task automatic write_reg(cfg_reg_t sel, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pool_config(sel, val);
  endtask

  // holds the request until its transfer, then records the predicted response
  task automatic send_req(req_type_t kind, logic [IDX_W-1:0] idx, logic [15:0] size,
                          bit typed, pool_rsp_t want, output pool_rsp_t got);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      gap = $urandom_range(1, 7);
    end else begin
      gap = 0;
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.block_index <= idx;
    req_ch.req_size    <= size;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    got = pool_step(kind, idx, size);
    due_rsp_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      fail_cnt++;
      if (fail_cnt <= 40) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // response stall pattern: open, coin flip, one in three, or held low
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
      2:       rsp_ch.ready <= (rx_left % 3 == 0);
      default: rsp_ch.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : rsp_check
    pool_rsp_t exp_r;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (due_rsp_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: response expected none actual status %0h index %0h", $time,
                 rsp_ch.status, rsp_ch.granted_index);
      end else begin
        exp_r = due_rsp_q.pop_front();
        check_field("status", exp_r.status, rsp_ch.status);
        check_field("granted_index", exp_r.gidx, rsp_ch.granted_index);
        check_field("block_address", exp_r.addr, rsp_ch.block_address);
        check_field("live_count", exp_r.live, rsp_ch.live_count);
        check_field("usage_bytes", exp_r.usage, rsp_ch.usage_bytes);
      end
    end
  end

  initial begin
    dir_row_t         dir_rows[$];
    dir_row_t         row;
    pool_rsp_t        got;
    logic [IDX_W-1:0] held[$];
    req_type_t        kind;
    logic [IDX_W-1:0] ix;
    logic [15:0]      sz;
    logic [31:0]      b;
    logic [7:0]       a;
    logic [15:0]      s;
    logic [23:0]      p;
    logic [31:0]      adj;
    logic [31:0]      junk;
    int               n;
    int               r;
    int               k;

    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = CFG_BASE;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_NOP;
    req_ch.block_index = '0;
    req_ch.req_size    = '0;
    rsp_ch.ready       = 1'b0;

    cfg_base  = BASE_RST;
    cfg_align = ALIGN_RST;
    cfg_osize = SIZE_RST;
    cfg_pool  = POOL_RST;
    usage_cnt = '0;
    pool_rebuild();

    // reset registers: 1024 blocks of 64 bytes from address 0
    dir_rows.push_back(row_chk(REQ_ALLOC, 10'd0, 16'd0, STAT_OK, 10'd0, 32'd0, 11'd1, 32'd0));
    dir_rows.push_back(row_chk(REQ_ALLOC, 10'd1023, 16'hFFFF, STAT_OK, 10'd1, 32'd64, 11'd2,
                               32'd65535));
    dir_rows.push_back(row_chk(REQ_FREE, 10'd1, 16'd0, STAT_OK, 10'd0, 32'd64, 11'd1,
                               32'd65471));
    // free of a block never handed out, then the same block again
    dir_rows.push_back(row_chk(REQ_FREE, 10'd1023, 16'd0, STAT_OK, 10'd0, 32'd65472, 11'd0,
                               32'd65407));
    dir_rows.push_back(row_chk(REQ_FREE, 10'd1023, 16'd0, STAT_OK, 10'd0, 32'd65472, 11'd0,
                               32'd65343));
    dir_rows.push_back(row_chk(REQ_NOP, 10'd1023, 16'hFFFF, STAT_OK, 10'd0, 32'd0, 11'd0,
                               32'd65343));
    dir_rows.push_back(row_chk(REQ_ALLOC, 10'd0, 16'd0, STAT_OK, 10'd1023, 32'd65472, 11'd1,
                               32'd65343));
    dir_rows.push_back(row_chk(REQ_CLEAR, 10'd0, 16'd0, STAT_OK, 10'd0, 32'd0, 11'd0,
                               32'd65343));
    // register writes without a clear: block count kept, addresses follow the registers
    dir_rows.push_back(row_cfg(CFG_BASE, 32'hFFFF_FFF5));
    dir_rows.push_back(row_chk(REQ_ALLOC, 10'd0, 16'd1, STAT_OK, 10'd0, 32'hFFFF_FFF8, 11'd1,
                               32'd65344));
    dir_rows.push_back(row_req(REQ_ALLOC, 10'd0, 16'd1));
    dir_rows.push_back(row_cfg(CFG_ALIGN, 32'd0));
    dir_rows.push_back(row_cfg(CFG_SIZE, 32'd0));
    dir_rows.push_back(row_req(REQ_ALLOC, 10'd0, 16'd0));
    // zero object size leaves no blocks
    dir_rows.push_back(row_req(REQ_CLEAR, 10'd0, 16'd0));
    dir_rows.push_back(row_chk(REQ_ALLOC, 10'd0, 16'd7, STAT_EMPTY, 10'd0, 32'd0, 11'd0,
                               32'd65345));
    dir_rows.push_back(row_chk(REQ_FREE, 10'd0, 16'd0, STAT_RANGE, 10'd0, 32'd0, 11'd0,
                               32'd65345));
    // largest registers
    dir_rows.push_back(row_cfg(CFG_SIZE, 32'h0000_FFFF));
    dir_rows.push_back(row_cfg(CFG_POOL, 32'h00FF_FFFF));
    dir_rows.push_back(row_cfg(CFG_ALIGN, 32'd128));
    dir_rows.push_back(row_cfg(CFG_BASE, 32'd1));
    dir_rows.push_back(row_req(REQ_CLEAR, 10'd0, 16'd0));
    dir_rows.push_back(row_req(REQ_ALLOC, 10'd0, 16'hFFFF));
    dir_rows.push_back(row_req(REQ_FREE, 10'd256, 16'd0));
    dir_rows.push_back(row_req(REQ_FREE, 10'd255, 16'd0));
    // pool smaller than the alignment adjustment
    dir_rows.push_back(row_cfg(CFG_POOL, 32'd100));
    dir_rows.push_back(row_req(REQ_CLEAR, 10'd0, 16'd0));
    dir_rows.push_back(row_req(REQ_ALLOC, 10'd0, 16'd0));
    // alignment that is not a power of two
    dir_rows.push_back(row_cfg(CFG_ALIGN, 32'd3));
    dir_rows.push_back(row_cfg(CFG_SIZE, 32'd4));
    dir_rows.push_back(row_cfg(CFG_POOL, 32'd50));
    dir_rows.push_back(row_req(REQ_CLEAR, 10'd0, 16'd0));
    dir_rows.push_back(row_req(REQ_ALLOC, 10'd0, 16'd0));
    dir_rows.push_back(row_req(REQ_FREE, 10'd11, 16'd0));
    dir_rows.push_back(row_req(REQ_FREE, 10'd12, 16'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_req(row.kind, row.idx, row.size, row.typed, row.want, got);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph % 6)
        0: begin
          // a handful of blocks, so the list runs dry often
          b   = $urandom;
          a   = 8'(1 << $urandom_range(0, 7));
          s   = 16'($urandom_range(4, 300));
          n   = $urandom_range(1, 12);
          adj = align_off(b, a);
          p   = 24'(adj + n * s + $urandom_range(0, s - 1));
        end
        1: begin
          b = $urandom;
          a = 8'(1 << $urandom_range(0, 7));
          s = 16'($urandom_range(4, 64));
          p = 24'hFF_FFFF;
        end
        2: begin
          b = $urandom;
          a = 8'($urandom_range(0, 255));
          s = 16'($urandom);
          p = 24'($urandom);
        end
        3: begin
          b = 32'hFFFF_FFFF;
          a = 8'd128;
          s = 16'hFFFF;
          p = 24'hFF_FFFF;
        end
        4: begin
          b = 32'd0;
          a = 8'($urandom_range(0, 1));
          s = 16'd4;
          p = 24'($urandom_range(0, 40));
        end
        default: begin
          b = $urandom;
          a = 8'($urandom_range(0, 255));
          s = 16'($urandom_range(0, 7));
          p = 24'($urandom_range(0, 200));
        end
      endcase
      // unused upper data bits must be ignored
      junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
      write_reg(CFG_BASE, b);
      write_reg(CFG_ALIGN, {junk[31:8], a});
      write_reg(CFG_SIZE, {junk[31:16], s});
      write_reg(CFG_POOL, {junk[31:24], p});
      held.delete();
      send_req(REQ_CLEAR, 10'($urandom), 16'($urandom), 1'b0, '0, got);

      for (int j = 0; j < 135; j++) begin
        r  = $urandom_range(0, 99);
        ix = 10'($urandom);
        case ($urandom_range(0, 9))
          0:       sz = 16'd0;
          1:       sz = 16'hFFFF;
          default: sz = 16'($urandom);
        endcase
        if (r < 44) begin
          kind = REQ_ALLOC;
        end else if (r < 84) begin
          if (held.size() != 0) begin
            k    = $urandom_range(0, held.size() - 1);
            ix   = held[k];
            held.delete(k);
            kind = REQ_FREE;
          end else begin
            kind = REQ_ALLOC;
          end
        end else if (r < 90) begin
          kind = REQ_FREE;
        end else if (r < 94) begin
          kind = REQ_FREE;
          if (block_cnt < NBLK) ix = 10'($urandom_range(block_cnt, NBLK - 1));
        end else if (r < 97) begin
          kind = REQ_NOP;
        end else begin
          kind = REQ_CLEAR;
        end
        send_req(kind, ix, sz, 1'b0, '0, got);
        if (kind == REQ_ALLOC && got.status == STAT_OK) held.push_back(got.gidx);
        if (kind == REQ_CLEAR) held.delete();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && due_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
